[rtl/nd_transpose_address_generator_top_assert.svh]
// Assertion macros for the transpose address generator.
`ifndef ND_TRANSPOSE_ADDRESS_GENERATOR_TOP_ASSERT_SVH
`define ND_TRANSPOSE_ADDRESS_GENERATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nta: same-cycle check failed");
`define NTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nta: next-cycle check failed");
`else
`define NTA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NTA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/nta_pkg.sv]
// Shared constants and types of the transpose address generator.
package nta_pkg;
    localparam int MAX_DIMS_DEF   = 4;
    localparam int DIM_BITS_DEF   = 16;
    localparam int INDEX_BITS_DEF = 32;
    localparam int CFG_W          = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int DCNT_BITS      = 3;
    localparam int PERM_BITS      = 8;
    localparam int EB_BITS        = 4;
    localparam int OFS_BITS       = 35;

    localparam logic [DCNT_BITS-1:0] DCNT_RST = 3'd4;
    localparam logic [PERM_BITS-1:0] PERM_RST = 8'd228;
    localparam logic [EB_BITS-1:0]   EB_RST   = 4'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_COUNT     = 3'd0,
        CFG_INPUT_SIZES   = 3'd1,
        CFG_OUTPUT_SIZES  = 3'd2,
        CFG_PERMUTATION   = 3'd3,
        CFG_ELEMENT_BYTES = 3'd4
    } t_cfg_reg;
endpackage

[rtl/nta_in_if.sv]
// Input word channel: destination index.
interface nta_in_if #(parameter int INDEX_BITS = 32);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] dest_index;
    modport source (output valid, output dest_index, input ready);
    modport sink   (input valid, input dest_index, output ready);
endinterface

[rtl/nta_out_if.sv]
// Output word channel: source index, byte offsets and flags.
interface nta_out_if #(parameter int INDEX_BITS = 32, parameter int OFS_BITS = 35);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] source_index;
    logic [OFS_BITS-1:0]   source_byte_offset;
    logic [OFS_BITS-1:0]   dest_byte_offset;
    logic                  size_mismatch;
    logic                  index_beyond;
    logic                  nothing_to_do;
    modport source (output valid, output source_index, output source_byte_offset,
                    output dest_byte_offset, output size_mismatch, output index_beyond,
                    output nothing_to_do, input ready);
    modport sink   (input valid, input source_index, input source_byte_offset,
                    input dest_byte_offset, input size_mismatch, input index_beyond,
                    input nothing_to_do, output ready);
endinterface

[rtl/nd_transpose_address_generator_top.sv]
// Top level of the N-dimensional transpose address generator.
//
//   channel   dir  handshake      contents
//   i_in      in   valid/ready    dest_index
//   o_out     out  valid/ready    source_index, byte offsets, three flags
//   i_cfg_*   in   write enable   register index, 64-bit data
//
// One word per cycle while the output buffer has room. The chain is
// MAX_DIMS*INDEX_BITS division steps (one quotient bit per cell), one digit
// placement stage, MAX_DIMS-1 Horner multiply stages, then the two-entry output buffer.
// Reset clears valid bits and config; no clearing pass.
// The whole chain stalls only when the output buffer holds two words.
// Size totals are rebuilt from config after a write, one factor per register stage.
module nd_transpose_address_generator_top #(
    parameter int MAX_DIMS   = nta_pkg::MAX_DIMS_DEF,
    parameter int DIM_BITS   = nta_pkg::DIM_BITS_DEF,
    parameter int INDEX_BITS = nta_pkg::INDEX_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [nta_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nta_pkg::CFG_W-1:0]      i_cfg_data,
    nta_in_if.sink                         i_in,
    nta_out_if.source                      o_out
);
    import nta_pkg::*;
`include "nd_transpose_address_generator_top_assert.svh"

    localparam int NCELL  = MAX_DIMS * INDEX_BITS;
    localparam int NHOR   = MAX_DIMS - 1;
    localparam int SEL_W  = $clog2(MAX_DIMS);
    localparam int EXT_W  = CFG_W + MAX_DIMS * DIM_BITS;
    localparam int MUL_W  = (INDEX_BITS + EB_BITS > OFS_BITS) ? INDEX_BITS + EB_BITS : OFS_BITS;
    localparam int PAY_W  = INDEX_BITS + 2 * OFS_BITS + 3;

    // ---------------- configuration registers ----------------
    logic [DCNT_BITS-1:0] r_dim_count;
    logic [CFG_W-1:0]     r_in_sizes, r_out_sizes;
    logic [PERM_BITS-1:0] r_perm;
    logic [EB_BITS-1:0]   r_eb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= DCNT_RST;
            r_in_sizes  <= '0;
            r_out_sizes <= '0;
            r_perm      <= PERM_RST;
            r_eb        <= EB_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_DIM_COUNT:     r_dim_count <= i_cfg_data[DCNT_BITS-1:0];
                CFG_INPUT_SIZES:   r_in_sizes  <= i_cfg_data;
                CFG_OUTPUT_SIZES:  r_out_sizes <= i_cfg_data;
                CFG_PERMUTATION:   r_perm      <= i_cfg_data[PERM_BITS-1:0];
                CFG_ELEMENT_BYTES: r_eb        <= i_cfg_data[EB_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- config-derived values ----------------
    // fields past bit 63 read as zero through the zero extension
    logic [EXT_W-1:0]                  in_ext, out_ext;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] isz, osz;
    logic [DCNT_BITS-1:0]              n_eff;
    logic [MAX_DIMS-1:0]               dim_act;
    logic                              idle;

    always_comb begin
        in_ext  = EXT_W'(r_in_sizes);
        out_ext = EXT_W'(r_out_sizes);
        n_eff   = (r_dim_count > DCNT_BITS'(MAX_DIMS)) ? DCNT_BITS'(MAX_DIMS) : r_dim_count;
        idle    = n_eff <= DCNT_BITS'(1);
        for (int j = 0; j < MAX_DIMS; j++) begin
            isz[j]     = in_ext[j*DIM_BITS +: DIM_BITS];
            osz[j]     = out_ext[j*DIM_BITS +: DIM_BITS];
            dim_act[j] = (DCNT_BITS'(j) < n_eff) && (osz[j] != '0);
        end
    end

    // where each output digit lands among the input positions;
    // on repeated axes the higher output dimension wins
    logic [MAX_DIMS-1:0][SEL_W-1:0] n_sel, r_sel;
    logic [MAX_DIMS-1:0]            n_sel_en, r_sel_en;

    always_comb begin
        int ni, k, ax;
        ni       = int'(n_eff);
        n_sel    = '0;
        n_sel_en = '0;
        for (int j = 0; j < MAX_DIMS; j++) begin
            k  = ni - 1 - j;
            ax = (k >= 0 && 2 * k < PERM_BITS) ? int'((r_perm >> (2 * k)) & 8'd3) : 0;
            for (int p = 0; p < MAX_DIMS; p++) begin
                if (j < ni && ax < ni && p == ni - 1 - ax) begin
                    n_sel[p]    = SEL_W'(j);
                    n_sel_en[p] = 1'b1;
                end
            end
        end
    end

    // element totals, one factor per register stage
    logic [MAX_DIMS-1:0][CFG_W-1:0] r_itot, r_otot;
    logic                           r_mismatch;

    always_ff @(posedge i_clk) begin
        r_sel    <= n_sel;
        r_sel_en <= n_sel_en;
        for (int j = 0; j < MAX_DIMS; j++) begin
            r_itot[j] <= CFG_W'(((j == 0) ? CFG_W'(1) : r_itot[j > 0 ? j - 1 : 0])
                         * ((DCNT_BITS'(j) < n_eff) ? isz[j] : DIM_BITS'(1)));
            r_otot[j] <= CFG_W'(((j == 0) ? CFG_W'(1) : r_otot[j > 0 ? j - 1 : 0])
                         * ((DCNT_BITS'(j) < n_eff) ? osz[j] : DIM_BITS'(1)));
        end
        r_mismatch <= r_itot[MAX_DIMS-1] != r_otot[MAX_DIMS-1];
    end

    // ---------------- flow control ----------------
    logic [1:0] r_cnt;
    logic       en;

    assign en         = r_cnt != 2'd2;
    assign i_in.ready = en;

    // ---------------- division chain ----------------
    logic [NCELL:0]                               d_vld;
    logic [NCELL:0][INDEX_BITS-1:0]               d_dest, d_num, d_orig;
    logic [NCELL:0][DIM_BITS-1:0]                 d_rem;
    logic [NCELL:0][MAX_DIMS-1:0][DIM_BITS-1:0]   d_dig;

    assign d_vld[0]  = i_in.valid && en;
    assign d_dest[0] = i_in.dest_index;
    assign d_num[0]  = i_in.dest_index;
    assign d_orig[0] = i_in.dest_index;
    assign d_rem[0]  = '0;
    assign d_dig[0]  = '0;

    for (genvar c = 0; c < NCELL; c++) begin : g_div
        localparam int DPOS = c / INDEX_BITS;
        localparam bit LAST = (c % INDEX_BITS) == INDEX_BITS - 1;
        nta_div_cell #(
            .INDEX_BITS(INDEX_BITS), .DIM_BITS(DIM_BITS), .MAX_DIMS(MAX_DIMS),
            .DIM_POS(DPOS), .LAST_BIT(LAST)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_vld(d_vld[c]), .i_dest(d_dest[c]), .i_num(d_num[c]), .i_rem(d_rem[c]),
            .i_orig(d_orig[c]), .i_dig(d_dig[c]), .i_div(osz[DPOS]),
            .i_active(dim_act[DPOS]),
            .o_vld(d_vld[c+1]), .o_dest(d_dest[c+1]), .o_num(d_num[c+1]),
            .o_rem(d_rem[c+1]), .o_orig(d_orig[c+1]), .o_dig(d_dig[c+1])
        );
    end

    // ---------------- digit placement ----------------
    logic [NHOR:0]                             h_vld;
    logic [NHOR:0][INDEX_BITS-1:0]             h_dest, h_src;
    logic [NHOR:0][MAX_DIMS-1:0][DIM_BITS-1:0] h_dig;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0]         placed;
    logic                                      r_p_vld;
    logic [INDEX_BITS-1:0]                     r_p_dest;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0]         r_p_dig;

    always_comb begin
        for (int p = 0; p < MAX_DIMS; p++) begin
            placed[p] = r_sel_en[p] ? d_dig[NCELL][r_sel[p]] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (en) begin
            r_p_vld <= d_vld[NCELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_dest <= d_dest[NCELL];
            r_p_dig  <= placed;
        end
    end

    assign h_vld[0]  = r_p_vld;
    assign h_dest[0] = r_p_dest;
    assign h_src[0]  = '0;
    assign h_dig[0]  = r_p_dig;

    // ---------------- Horner chain, outermost position first ----------------
    for (genvar h = 0; h < NHOR; h++) begin : g_hor
        localparam int HPOS = MAX_DIMS - 1 - h;
        nta_horner_cell #(
            .INDEX_BITS(INDEX_BITS), .DIM_BITS(DIM_BITS), .MAX_DIMS(MAX_DIMS), .POS(HPOS)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_vld(h_vld[h]), .i_dest(h_dest[h]), .i_src(h_src[h]), .i_dig(h_dig[h]),
            .i_mul(isz[HPOS-1]),
            .o_vld(h_vld[h+1]), .o_dest(h_dest[h+1]), .o_src(h_src[h+1]),
            .o_dig(h_dig[h+1])
        );
    end

    // ---------------- final add, byte offsets, flags ----------------
    logic [INDEX_BITS-1:0] src_fin;
    logic [MUL_W-1:0]      sofs, dofs;
    logic                  beyond, push, pop;
    logic [PAY_W-1:0]      pay_new, r_q0, r_q1;

    always_comb begin
        src_fin = idle ? '0 : h_src[NHOR] + INDEX_BITS'(h_dig[NHOR][0]);
        sofs    = MUL_W'(src_fin) * MUL_W'(r_eb);
        dofs    = MUL_W'(h_dest[NHOR]) * MUL_W'(r_eb);
        beyond  = CFG_W'(h_dest[NHOR]) >= r_otot[MAX_DIMS-1];
        pay_new = {src_fin, sofs[OFS_BITS-1:0], dofs[OFS_BITS-1:0], r_mismatch, beyond, idle};
    end

    // ---------------- two-word output buffer ----------------
    assign push = en && h_vld[NHOR];
    assign pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q0 <= (r_cnt == 2'd2) ? r_q1 : pay_new;
        end else if (push && r_cnt == 2'd0) begin
            r_q0 <= pay_new;
        end
        if (push && ((r_cnt == 2'd1 && !pop) || r_cnt == 2'd2)) begin
            r_q1 <= pay_new;
        end
    end

    assign o_out.valid = r_cnt != 2'd0;
    assign {o_out.source_index, o_out.source_byte_offset, o_out.dest_byte_offset,
            o_out.size_mismatch, o_out.index_beyond, o_out.nothing_to_do} = r_q0;

    // ---------------- checks ----------------
    logic idle_src_zero;

    assign idle_src_zero = o_out.source_index == '0 && o_out.source_byte_offset == '0;

    `NTA_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `NTA_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, r_cnt == 2'd2, !i_in.ready)
    `NTA_ASSERT_NXT(a_drain, i_clk, i_rst_n, pop && !push && r_cnt == 2'd1, !o_out.valid)
    `NTA_ASSERT_IMP(a_idle_zero, i_clk, i_rst_n, o_out.valid && o_out.nothing_to_do, idle_src_zero)
endmodule

[rtl/nta_div_cell.sv]
// One restoring-division step; the last step of a dimension stores the digit.
module nta_div_cell #(
    parameter int INDEX_BITS = 32,
    parameter int DIM_BITS   = 16,
    parameter int MAX_DIMS   = 4,
    parameter int DIM_POS    = 0,
    parameter bit LAST_BIT   = 1'b0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  logic [INDEX_BITS-1:0]              i_dest,
    input  logic [INDEX_BITS-1:0]              i_num,
    input  logic [DIM_BITS-1:0]                i_rem,
    input  logic [INDEX_BITS-1:0]              i_orig,
    input  logic [MAX_DIMS-1:0][DIM_BITS-1:0]  i_dig,
    input  logic [DIM_BITS-1:0]                i_div,
    input  logic                               i_active,
    output logic                               o_vld,
    output logic [INDEX_BITS-1:0]              o_dest,
    output logic [INDEX_BITS-1:0]              o_num,
    output logic [DIM_BITS-1:0]                o_rem,
    output logic [INDEX_BITS-1:0]              o_orig,
    output logic [MAX_DIMS-1:0][DIM_BITS-1:0]  o_dig
);
    logic                              r_vld;
    logic [INDEX_BITS-1:0]             r_dest, r_num, r_orig;
    logic [DIM_BITS-1:0]               r_rem;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] r_dig;
    logic [INDEX_BITS-1:0]             n_num, n_orig, num_step, rest;
    logic [DIM_BITS-1:0]               n_rem, rem_step;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] n_dig;
    logic [DIM_BITS:0]                 part, diff;
    logic                              ge;

    always_comb begin
        part     = {i_rem, i_num[INDEX_BITS-1]};
        diff     = part - {1'b0, i_div};
        ge       = part >= {1'b0, i_div};
        rem_step = ge ? diff[DIM_BITS-1:0] : part[DIM_BITS-1:0];
        num_step = {i_num[INDEX_BITS-2:0], ge};
        rest     = i_active ? num_step : i_orig;
        n_dig    = i_dig;
        if (LAST_BIT) begin
            // dimension done: quotient moves on, remainder becomes the digit (inactive: number passes on, digit zero)
            n_num          = rest;
            n_rem          = '0;
            n_orig         = rest;
            n_dig[DIM_POS] = i_active ? rem_step : '0;
        end else begin
            n_num  = num_step;
            n_rem  = rem_step;
            n_orig = i_orig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dest <= i_dest;
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_orig <= n_orig;
            r_dig  <= n_dig;
        end
    end

    assign o_vld  = r_vld;
    assign o_dest = r_dest;
    assign o_num  = r_num;
    assign o_rem  = r_rem;
    assign o_orig = r_orig;
    assign o_dig  = r_dig;
endmodule

[rtl/nta_horner_cell.sv]
// One Horner step: (src + digit) * input size of the next inner dimension.
module nta_horner_cell #(
    parameter int INDEX_BITS = 32,
    parameter int DIM_BITS   = 16,
    parameter int MAX_DIMS   = 4,
    parameter int POS        = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  logic [INDEX_BITS-1:0]              i_dest,
    input  logic [INDEX_BITS-1:0]              i_src,
    input  logic [MAX_DIMS-1:0][DIM_BITS-1:0]  i_dig,
    input  logic [DIM_BITS-1:0]                i_mul,
    output logic                               o_vld,
    output logic [INDEX_BITS-1:0]              o_dest,
    output logic [INDEX_BITS-1:0]              o_src,
    output logic [MAX_DIMS-1:0][DIM_BITS-1:0]  o_dig
);
    logic                              r_vld;
    logic [INDEX_BITS-1:0]             r_dest, r_src, n_src, sum;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] r_dig;
    logic [INDEX_BITS+DIM_BITS-1:0]    prod;

    always_comb begin
        sum   = i_src + INDEX_BITS'(i_dig[POS]);
        prod  = (INDEX_BITS+DIM_BITS)'(sum) * (INDEX_BITS+DIM_BITS)'(i_mul);
        n_src = prod[INDEX_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dest <= i_dest;
            r_src  <= n_src;
            r_dig  <= i_dig;
        end
    end

    assign o_vld  = r_vld;
    assign o_dest = r_dest;
    assign o_src  = r_src;
    assign o_dig  = r_dig;
endmodule
